### src/undo_redo_checkpoint_array_top_assert.svh
// assertion macros for the undo/redo checkpoint array port checker
// expects clk and arst_n in the scope where a macro is used
`ifndef UNDO_REDO_CHECKPOINT_ARRAY_TOP_ASSERT_SVH
`define UNDO_REDO_CHECKPOINT_ARRAY_TOP_ASSERT_SVH

// same-cycle implication
`define URCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urca port check failed");

// next-cycle implication
`define URCA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urca port check failed");

`endif

### src/urca_pkg.sv
// shared constants, codes and command/status types of the undo/redo checkpoint array
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package urca_pkg;

	localparam int ENTRIES   = 16;
	localparam int DEPTH     = 4;

	localparam int KIND_W    = 2;
	localparam int IDX_W     = 8;
	localparam int VAL_W     = 32;
	localparam int STS_W     = 2;
	localparam int DEP_W     = 3;

	localparam int RANGE_W   = IDX_W + 1;
	localparam int EA_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int MEM_DEPTH = DEPTH * ENTRIES;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUB  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNDO = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REDO = 2'd3;

	localparam logic [STS_W-1:0] STS_OK         = 2'd0;
	localparam logic [STS_W-1:0] STS_RANGE      = 2'd1;
	localparam logic [STS_W-1:0] STS_UNDO_EMPTY = 2'd2;
	localparam logic [STS_W-1:0] STS_REDO_EMPTY = 2'd3;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic copy_rd;
		logic resp;
	} dp_cmd_t;

	typedef struct packed {
		logic proceed;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

### src/urca_ctrl.sv
// sequencer for the undo/redo checkpoint array: item intake, array copy sweep, report
// depends on urca_pkg
`timescale 1ns / 1ps
`default_nettype none

module urca_ctrl import urca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_COPY  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.cnt_clr = 1'b1;
				state_n     = stat.proceed ? S_COPY : S_READ;
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				if (stat.last) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_n = S_READ;
			end
			S_READ: begin
				state_n = S_RESP;
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				state_n  = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### src/urca_dp.sv
// datapath of the undo/redo checkpoint array: entry memory, undo and redo snapshot
// memories, stack pointers and result registers; depends on urca_pkg
`timescale 1ns / 1ps
`default_nettype none

module urca_dp import urca_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [KIND_W-1:0]       kind,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [VAL_W-1:0] value,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	output logic [STS_W-1:0]        status,
	output logic signed [VAL_W-1:0] value_at_index,
	output logic [DEP_W-1:0]        undo_depth,
	output logic [DEP_W-1:0]        redo_depth,
	output logic                    done
);

	function automatic logic [SLOT_W-1:0] head_inc(input logic [SLOT_W-1:0] h);
		logic [31:0] nx;
		nx = 32'(h) + 32'd1;
		return (nx >= 32'(DEPTH)) ? '0 : nx[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] head_dec(input logic [SLOT_W-1:0] h);
		return (h == '0) ? SLOT_W'(DEPTH - 1) : h - 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		return (c < CNT_W'(DEPTH)) ? c + 1'b1 : c;
	endfunction

	function automatic logic [MEM_AW-1:0] snap_addr(input logic [SLOT_W-1:0] slot,
			input logic [EA_W-1:0] ent);
		logic [31:0] lin;
		lin = 32'(slot) * 32'(ENTRIES) + 32'(ent);
		return lin[MEM_AW-1:0];
	endfunction

	function automatic logic [DEP_W-1:0] depth3(input logic [CNT_W-1:0] c);
		logic [CNT_W+DEP_W-1:0] w;
		w = {{DEP_W{1'b0}}, c};
		return w[DEP_W-1:0];
	endfunction

	// latched item
	logic [KIND_W-1:0]       kind_q;
	logic [IDX_W-1:0]        index_q;
	logic signed [VAL_W-1:0] value_q;

	// stack pointers
	logic [CNT_W-1:0]  ucnt_q, rcnt_q, ucnt_n, rcnt_n;
	logic [SLOT_W-1:0] uhead_q, rhead_q, uhead_n, rhead_n;

	// copy sweep
	logic [EA_W-1:0] cnt_q;
	logic [EA_W-1:0] cnt_s1;
	logic            copy_s1;

	// memories
	logic [VAL_W-1:0]   cur_mem  [ENTRIES];
	logic [ENTRIES-1:0] cur_vld_q;
	logic [VAL_W-1:0]   cur_rd_q;
	logic               cur_rdv_q;
	logic [VAL_W-1:0]   undo_mem [MEM_DEPTH];
	logic [VAL_W-1:0]   redo_mem [MEM_DEPTH];
	logic [VAL_W-1:0]   undo_rd_q;
	logic [VAL_W-1:0]   redo_rd_q;

	// result registers
	logic [STS_W-1:0] status_q;
	logic [VAL_W-1:0] val_q;
	logic [DEP_W-1:0] udep_q, rdep_q;
	logic             done_q;

	logic              in_range;
	logic [EA_W-1:0]   idx_a;
	logic              is_edit;
	logic              proceed;
	logic [STS_W-1:0]  status_n;
	logic [SLOT_W-1:0] upop, rpop;
	logic [MEM_AW-1:0] undo_ra, redo_ra, undo_wa, redo_wa;
	logic [EA_W-1:0]   cur_ra, cur_wa;
	logic              cur_we, undo_we, redo_we;
	logic [VAL_W-1:0]  cur_wd, cur_dat, sum, res_val;

	assign in_range = {1'b0, index_q} < RANGE_W'(ENTRIES);
	assign idx_a    = index_q[EA_W-1:0];
	assign is_edit  = (kind_q == KIND_ADD) || (kind_q == KIND_SUB);
	assign upop     = head_dec(uhead_q);
	assign rpop     = head_dec(rhead_q);

	always_comb begin
		proceed  = 1'b0;
		status_n = STS_OK;
		ucnt_n   = ucnt_q;
		rcnt_n   = rcnt_q;
		uhead_n  = uhead_q;
		rhead_n  = rhead_q;
		unique case (kind_q)
			KIND_ADD, KIND_SUB: begin
				proceed  = in_range;
				status_n = in_range ? STS_OK : STS_RANGE;
				if (in_range) begin
					ucnt_n  = cnt_inc(ucnt_q);
					uhead_n = head_inc(uhead_q);
					rcnt_n  = '0;
					rhead_n = '0;
				end
			end
			KIND_UNDO: begin
				proceed  = (ucnt_q != '0);
				status_n = !proceed ? STS_UNDO_EMPTY : (in_range ? STS_OK : STS_RANGE);
				if (proceed) begin
					rcnt_n  = cnt_inc(rcnt_q);
					rhead_n = head_inc(rhead_q);
					ucnt_n  = ucnt_q - 1'b1;
					uhead_n = upop;
				end
			end
			KIND_REDO: begin
				proceed  = (rcnt_q != '0);
				status_n = !proceed ? STS_REDO_EMPTY : (in_range ? STS_OK : STS_RANGE);
				if (proceed) begin
					ucnt_n  = cnt_inc(ucnt_q);
					uhead_n = head_inc(uhead_q);
					rcnt_n  = rcnt_q - 1'b1;
					rhead_n = rpop;
				end
			end
		endcase
	end

	assign stat.proceed = proceed;
	assign stat.last    = (cnt_q == EA_W'(ENTRIES - 1));

	// addresses: reads at the sweep counter, writes at its registered copy in the next cycle
	assign undo_ra = snap_addr(upop, cnt_q);
	assign redo_ra = snap_addr(rpop, cnt_q);
	assign undo_wa = snap_addr(uhead_q, cnt_s1);
	assign redo_wa = snap_addr(rhead_q, cnt_s1);
	assign cur_ra  = cmd.copy_rd ? cnt_q : idx_a;

	assign cur_dat = cur_rdv_q ? cur_rd_q : '0;
	assign sum     = (kind_q == KIND_ADD) ? cur_dat + VAL_W'(value_q)
	                                      : cur_dat - VAL_W'(value_q);
	assign res_val = !in_range ? '0 : (is_edit ? sum : cur_dat);

	assign undo_we = copy_s1 && (kind_q != KIND_UNDO);
	assign redo_we = copy_s1 && (kind_q == KIND_UNDO);
	assign cur_we  = (copy_s1 && !is_edit) || (cmd.resp && is_edit && in_range);
	assign cur_wa  = copy_s1 ? cnt_s1 : idx_a;
	assign cur_wd  = copy_s1 ? ((kind_q == KIND_UNDO) ? undo_rd_q : redo_rd_q) : sum;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			index_q <= index;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucnt_q  <= '0;
			rcnt_q  <= '0;
			uhead_q <= '0;
			rhead_q <= '0;
			cnt_q   <= '0;
			copy_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_rd;
			done_q  <= cmd.resp;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.copy_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.resp) begin
				ucnt_q  <= ucnt_n;
				rcnt_q  <= rcnt_n;
				uhead_q <= uhead_n;
				rhead_q <= rhead_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_q;
		if (cmd.resp) begin
			status_q <= status_n;
			val_q    <= res_val;
			udep_q   <= depth3(ucnt_n);
			rdep_q   <= depth3(rcnt_n);
		end
	end

	// entry memory, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= '0;
		end else if (cur_we) begin
			cur_vld_q[cur_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_q  <= cur_mem[cur_ra];
		cur_rdv_q <= cur_vld_q[cur_ra];
	end

	always_ff @(posedge clk) begin
		if (undo_we) begin
			undo_mem[undo_wa] <= cur_dat;
		end
		undo_rd_q <= undo_mem[undo_ra];
	end

	always_ff @(posedge clk) begin
		if (redo_we) begin
			redo_mem[redo_wa] <= cur_dat;
		end
		redo_rd_q <= redo_mem[redo_ra];
	end

	assign status         = status_q;
	assign value_at_index = val_q;
	assign undo_depth     = udep_q;
	assign redo_depth     = rdep_q;
	assign done           = done_q;

endmodule

`default_nettype wire

### src/undo_redo_checkpoint_array_top.sv
// top level of the undo/redo checkpoint array: controller plus datapath
// depends on urca_pkg, urca_ctrl, urca_dp
`timescale 1ns / 1ps
`default_nettype none

// usage
//   an item (kind, index, value) is taken at a rising edge with start high and busy low
//   kind: add, subtract, undo, redo; index picks the entry edited and reported
//   each item gives one result (status, value_at_index, undo_depth, redo_depth),
//   shown for one cycle with done high; the receiver cannot stall it
// sweep and back-to-back items
//   an item that changes the stacks sweeps the entry array once, one entry per
//   cycle over the entry memory's single read port; an item that fails its
//   check skips the sweep
//   busy drops in the cycle done is high, so the next item can be taken then;
//   no new item is taken while one is in progress
// reset
//   arst_n low clears all entries to zero and empties both stacks; no clearing
//   pass, the block takes an item right after reset

module undo_redo_checkpoint_array_top import urca_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [KIND_W-1:0]       kind,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [VAL_W-1:0] value,
	output logic                    busy,
	output logic                    done,
	output logic [STS_W-1:0]        status,
	output logic signed [VAL_W-1:0] value_at_index,
	output logic [DEP_W-1:0]        undo_depth,
	output logic [DEP_W-1:0]        redo_depth
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	urca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	urca_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.index          (index),
		.value          (value),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.value_at_index (value_at_index),
		.undo_depth     (undo_depth),
		.redo_depth     (redo_depth),
		.done           (done)
	);

endmodule

`default_nettype wire

### src/urca_checker.sv
// port checker for the undo/redo checkpoint array, bound to the top level
// depends on urca_pkg and undo_redo_checkpoint_array_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "undo_redo_checkpoint_array_top_assert.svh"

module urca_checker import urca_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [STS_W-1:0]        status,
	input logic signed [VAL_W-1:0] value_at_index
);

	// a result only shows once the item is finished
	`URCA_ASSERT_IMP(a_done_idle, done, !busy)
	// a taken item keeps the block busy
	`URCA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// one item, one result strobe
	`URCA_ASSERT_NXT(a_done_pulse, done, !done)
	// finishing an item always delivers its result
	`URCA_ASSERT_IMP(a_busy_fall_done, $fell(busy), done)
	// an out-of-range index reports a zero entry
	`URCA_ASSERT_IMP(a_range_zero, done && (status == STS_RANGE), value_at_index == '0)

endmodule

bind undo_redo_checkpoint_array_top urca_checker u_chk (.*);

`default_nettype wire
